// ===== rtl/gbr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_pkg
// Shared constants, types and kernel weights for the RGB Gaussian blur.
// ----------------------------------------------------------------------------
package gbr_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_TAPS_DEF  = 5;
	localparam int MAX_HEIGHT    = 4096;

	localparam int PIX_W  = 8;
	localparam int WORD_W = 3 * PIX_W;
	localparam int FW_W   = 11;
	localparam int FH_W   = 13;
	localparam int CFG_W  = 13;
	localparam int SUM_W  = 17;
	localparam int PROD_W = 36;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	// floor(x/546) = (x * RECIP_546) >> RECIP_SHIFT for every x up to 249475
	localparam logic [17:0] RECIP_546   = 18'd245821;
	localparam int          RECIP_SHIFT = 27;

	typedef enum logic [1:0] {
		CFG_KERNEL_MODE  = 2'd0,
		CFG_FRAME_WIDTH  = 2'd1,
		CFG_FRAME_HEIGHT = 2'd2,
		CFG_UNUSED       = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic en;    // whole pipeline advances
		logic shift; // a word enters the window
		logic five;  // 5x5 kernel for the word in the window
	} lane_ctl_t;

	localparam logic [5:0] K3 [3][3] = '{
		'{6'd1, 6'd2, 6'd1},
		'{6'd2, 6'd4, 6'd2},
		'{6'd1, 6'd2, 6'd1}
	};

	localparam logic [5:0] K5 [5][5] = '{
		'{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
		'{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
		'{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
		'{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
		'{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
	};

	// weight of window tap (row k, column j); taps outside the kernel weigh zero
	function automatic logic [5:0] gbr_weight(input logic five, input int k, input int j);
		logic [5:0] w;
		w = '0;
		if (five) begin
			if (k < 5 && j < 5) w = K5[k][j];
		end else if (k < 3 && j < 3) begin
			w = K3[k][j];
		end
		return w;
	endfunction

endpackage

// ===== rtl/gbr_line_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_line_buf
// Row delay lines: one memory per buffered row, each with a registered read
// ahead and write-to-read forwarding for one-pixel-wide frames.
// ----------------------------------------------------------------------------
module gbr_line_buf #(
	parameter int MAX_WIDTH = gbr_pkg::MAX_WIDTH_DEF,
	parameter int LINES     = gbr_pkg::MAX_TAPS_DEF - 1,
	parameter int AW        = $clog2(MAX_WIDTH)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [AW-1:0]             rd_addr,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [gbr_pkg::WORD_W-1:0] wr_data [LINES],
	output logic [gbr_pkg::WORD_W-1:0] rd_data [LINES]
);

	logic                       hit_q;

	// flag a read of the address being written this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (en) begin
			hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	for (genvar l = 0; l < LINES; l++) begin : g_line
		logic [gbr_pkg::WORD_W-1:0] mem [MAX_WIDTH];
		logic [gbr_pkg::WORD_W-1:0] raw_q;
		logic [gbr_pkg::WORD_W-1:0] byp_q;

		// write the column word, read ahead for the next word
		always_ff @(posedge clk) begin
			if (wr_en) mem[wr_addr] <= wr_data[l];
			if (en) begin
				raw_q <= mem[rd_addr];
				byp_q <= wr_data[l];
			end
		end

		assign rd_data[l] = hit_q ? byp_q : raw_q;
	end

endmodule

// ===== rtl/gbr_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_lane
// One color channel: window registers, weighted row sums, total, rounding
// divide and clamp.
// ----------------------------------------------------------------------------
module gbr_lane #(
	parameter int TAPS = gbr_pkg::MAX_TAPS_DEF
) (
	input  logic                     clk,
	input  gbr_pkg::lane_ctl_t       ctl,
	input  logic [gbr_pkg::PIX_W-1:0] col_in [TAPS],
	input  logic [TAPS*TAPS-1:0]     mask,
	output logic [gbr_pkg::PIX_W-1:0] pix_out
);

	logic [gbr_pkg::PIX_W-1:0]  win_q [TAPS][TAPS];
	logic [gbr_pkg::SUM_W-1:0]  row_s3 [TAPS];
	logic [gbr_pkg::SUM_W-1:0]  row_sum [TAPS];
	logic [gbr_pkg::SUM_W-1:0]  sum_s4;
	logic [gbr_pkg::SUM_W-1:0]  total;
	logic [gbr_pkg::PROD_W-1:0] prod_s5;
	logic [gbr_pkg::PIX_W:0]    quot;
	logic                       five_s3, five_s4, five_s5;
	logic [gbr_pkg::PIX_W-1:0]  pix_s6;

	// weight and sum each window row, zero taps outside the frame
	always_comb begin
		for (int k = 0; k < TAPS; k++) begin
			row_sum[k] = '0;
			for (int j = 0; j < TAPS; j++) begin
				if (mask[k*TAPS+j]) begin
					row_sum[k] = row_sum[k] +
						gbr_pkg::SUM_W'(gbr_pkg::gbr_weight(ctl.five, k, j)) *
						gbr_pkg::SUM_W'(win_q[k][j]);
				end
			end
		end
		total = '0;
		for (int k = 0; k < TAPS; k++) total = total + row_s3[k];
		quot = five_s5 ? prod_s5[gbr_pkg::RECIP_SHIFT +: gbr_pkg::PIX_W+1]
		               : prod_s5[gbr_pkg::PIX_W:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			// shift the window, newest column at tap 0
			if (ctl.shift) begin
				for (int k = 0; k < TAPS; k++) begin
					for (int j = TAPS-1; j > 0; j--) win_q[k][j] <= win_q[k][j-1];
					win_q[k][0] <= col_in[k];
				end
			end
			row_s3  <= row_sum;
			five_s3 <= ctl.five;
			sum_s4  <= total;
			five_s4 <= five_s3;
			// round: 5x5 by reciprocal of 546 on 2S+273, 3x3 by (S+8)>>4
			if (five_s4) begin
				prod_s5 <= gbr_pkg::PROD_W'({1'b0, sum_s4, 1'b0} + 19'd273)
				           * gbr_pkg::PROD_W'(gbr_pkg::RECIP_546);
			end else begin
				prod_s5 <= gbr_pkg::PROD_W'((sum_s4 + gbr_pkg::SUM_W'(8)) >> 4);
			end
			five_s5 <= five_s4;
			pix_s6  <= (quot > 9'd255) ? 8'd255 : quot[gbr_pkg::PIX_W-1:0];
		end
	end

	assign pix_out = pix_s6;

endmodule

// ===== rtl/gaussian_blur_rgb_stream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_blur_rgb_stream
// Gaussian blur (3x3 over 16 or 5x5 over 273) of an RGB raster stream.
// ----------------------------------------------------------------------------
// Takes one word per clock and returns one blurred word per clock once the
// window is primed and out_ready does not stall; results trail the input
// by pad*width+pad words (pad is 1 for 3x3 and 2 for 5x5), so a frame is
// followed by that many drain words. Pipeline steps in order: counters and
// tap masks, row memory read, window, row sums, total, rounding multiply,
// output register. Throughput is set by the single write and read port of
// each row memory, serving one column per unstalled cycle. Red, green and
// blue lanes merge at the output; out_ready low stalls the whole pipeline.
// ----------------------------------------------------------------------------
module gaussian_blur_rgb_stream #(
	parameter int MAX_WIDTH = gbr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_TAPS  = gbr_pkg::MAX_TAPS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [1:0]               cfg_index,
	input  logic [gbr_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     kind,
	input  logic [7:0]               blue_in,
	input  logic [7:0]               green_in,
	input  logic [7:0]               red_in,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [7:0]               blue_out,
	output logic [7:0]               green_out,
	output logic [7:0]               red_out,
	output logic                     frame_end
);

	localparam int T     = MAX_TAPS;
	localparam int LINES = MAX_TAPS - 1;
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = gbr_pkg::FH_W;
	localparam int PW    = $clog2(MAX_WIDTH * gbr_pkg::MAX_HEIGHT + 2 * MAX_WIDTH + 3);
	localparam int SW    = HW + 3;

	// configuration registers
	logic                     mode_q;
	logic [gbr_pkg::FW_W-1:0] fw_q;
	logic [gbr_pkg::FH_W-1:0] fh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			fw_q   <= gbr_pkg::FRAME_WIDTH_RST;
			fh_q   <= gbr_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_wr_en) begin
			case (gbr_pkg::cfg_idx_t'(cfg_index))
				gbr_pkg::CFG_KERNEL_MODE:  mode_q <= cfg_wdata[0];
				gbr_pkg::CFG_FRAME_WIDTH:  fw_q   <= cfg_wdata[gbr_pkg::FW_W-1:0];
				gbr_pkg::CFG_FRAME_HEIGHT: fh_q   <= cfg_wdata[gbr_pkg::FH_W-1:0];
				default: ;
			endcase
		end
	end

	// effective geometry
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic          five;
	logic [1:0]    pad;
	logic [PW-1:0] lag, total;
	logic [12:0]   fw_ext;

	always_comb begin
		fw_ext = 13'(fw_q);
		if (fw_q == '0)                    w_eff = WW'(1);
		else if (fw_ext > 13'(MAX_WIDTH))  w_eff = WW'(MAX_WIDTH);
		else                               w_eff = WW'(fw_ext);
		if (fh_q == '0)                                  h_eff = HW'(1);
		else if (fh_q > HW'(gbr_pkg::MAX_HEIGHT))        h_eff = HW'(gbr_pkg::MAX_HEIGHT);
		else                                             h_eff = fh_q;
		five  = mode_q && (MAX_TAPS >= 5);
		pad   = five ? 2'd2 : 2'd1;
		lag   = five ? (PW'(w_eff) << 1) + PW'(2) : PW'(w_eff) + PW'(1);
		total = PW'(w_eff) * PW'(h_eff);
	end

	// stream position counters
	logic [CW-1:0] col_q, oc_q;
	logic [HW-1:0] orow_q;
	logic [PW-1:0] pos_q, opos_q;
	logic          en, acc, emit, last;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign acc      = in_valid && in_ready;
	assign emit     = pos_q >= lag;
	assign last     = opos_q >= total - PW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			pos_q  <= '0;
			opos_q <= '0;
			oc_q   <= '0;
			orow_q <= '0;
		end else if (acc) begin
			if (emit && last) begin
				col_q  <= '0;
				pos_q  <= '0;
				opos_q <= '0;
				oc_q   <= '0;
				orow_q <= '0;
			end else begin
				col_q <= (WW'(col_q) + WW'(1) >= w_eff) ? '0 : col_q + CW'(1);
				pos_q <= pos_q + PW'(1);
				if (emit) begin
					opos_q <= opos_q + PW'(1);
					if (WW'(oc_q) + WW'(1) >= w_eff) begin
						oc_q   <= '0;
						orow_q <= orow_q + HW'(1);
					end else begin
						oc_q <= oc_q + CW'(1);
					end
				end
			end
		end
	end

	// tap masks: drop window rows and columns outside the frame
	logic [T-1:0]   row_ok, col_ok;
	logic [T*T-1:0] mask;
	logic signed [SW-1:0] rr, cc;

	always_comb begin
		for (int k = 0; k < T; k++) begin
			rr = $signed(SW'(orow_q)) + $signed(SW'(pad)) - $signed(SW'(k));
			cc = $signed(SW'(oc_q)) + $signed(SW'(pad)) - $signed(SW'(k));
			row_ok[k] = (rr >= 0) && (rr < $signed(SW'(h_eff)));
			col_ok[k] = (cc >= 0) && (cc < $signed(SW'(w_eff)));
		end
		for (int k = 0; k < T; k++)
			for (int j = 0; j < T; j++)
				mask[k*T+j] = row_ok[k] && col_ok[j];
	end

	// stage 1: sample and control
	logic                       a_s1, e_s1, l_s1, f_s1;
	logic [T*T-1:0]             mask_s1;
	logic [gbr_pkg::WORD_W-1:0] sample_s1;
	logic [CW-1:0]              col_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_s1 <= 1'b0;
		end else if (en) begin
			a_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1      <= emit;
			l_s1      <= last;
			f_s1      <= five;
			mask_s1   <= mask;
			col_s1    <= col_q;
			sample_s1 <= (!kind && pos_q < total) ? {red_in, green_in, blue_in} : '0;
		end
	end

	// row memories and the column word entering the window
	logic [gbr_pkg::WORD_W-1:0] rd_data [LINES];
	logic [gbr_pkg::WORD_W-1:0] colv [T];

	always_comb begin
		colv[0] = sample_s1;
		for (int k = 1; k < T; k++) colv[k] = rd_data[k-1];
	end

	gbr_line_buf #(
		.MAX_WIDTH (MAX_WIDTH),
		.LINES     (LINES),
		.AW        (CW)
	) u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.rd_addr (col_q),
		.wr_en   (en && a_s1),
		.wr_addr (col_s1),
		.wr_data (colv[0:LINES-1]),
		.rd_data (rd_data)
	);

	// result control through the lane stages
	logic           v_s2, v_s3, v_s4, v_s5, v_s6;
	logic           l_s2, l_s3, l_s4, l_s5, l_s6;
	logic           f_s2;
	logic [T*T-1:0] mask_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
		end else if (en) begin
			v_s2 <= a_s1 && e_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s2 <= l_s1;
			l_s3 <= l_s2;
			l_s4 <= l_s3;
			l_s5 <= l_s4;
			l_s6 <= l_s5;
			if (a_s1) f_s2 <= f_s1;
			mask_s2 <= mask_s1;
		end
	end

	gbr_pkg::lane_ctl_t ctl;
	assign ctl = '{en: en, shift: a_s1, five: f_s2};

	// three channel lanes, merged in the output word
	logic [7:0] lane_out [3];

	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		logic [7:0] lane_col [T];
		always_comb begin
			for (int k = 0; k < T; k++) lane_col[k] = colv[k][ch*8 +: 8];
		end
		gbr_lane #(
			.TAPS (T)
		) u_lane (
			.clk     (clk),
			.ctl     (ctl),
			.col_in  (lane_col),
			.mask    (mask_s2),
			.pix_out (lane_out[ch])
		);
	end

	assign out_valid = v_s6;
	assign blue_out  = lane_out[0];
	assign green_out = lane_out[1];
	assign red_out   = lane_out[2];
	assign frame_end = l_s6;

	// checks
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		acc && emit && last |=> pos_q == '0 && opos_q == '0)
		else $error("counters not cleared after last result");
	a_out_behind_in: assert property (@(posedge clk) disable iff (!arst_n)
		opos_q <= pos_q)
		else $error("output position ahead of input position");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && !out_ready |=> v_s6 && $stable(l_s6))
		else $error("result dropped under stall");

endmodule
